// ----- rtl/cct_pkg.sv -----
// Shared constants, codes and types for the compacting client table.
`default_nettype none
package cct_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int ADDR_W      = 32;
    localparam int OP_W        = 2;
    localparam int LIMIT_W     = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 3;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    localparam logic [OP_W-1:0] OP_CONNECT    = 2'd0;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic do_append;
        logic do_remove;
        logic do_clear;
    } cct_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/cct_if.sv -----
// Request and response channel interfaces of the client table.
`default_nettype none
interface cct_req_if
    import cct_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] client_address;

    modport source (output valid, output opcode, output client_address, input ready);
    modport sink (input valid, input opcode, input client_address, output ready);
endinterface

interface cct_rsp_if
    import cct_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [COUNT_OUT_W-1:0] client_count;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output client_count, output status, input ready);
    modport sink (input valid, input client_count, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/cct_cell.sv -----
// One slot of the table: stored address, valid flag, match and shift logic.
`default_nettype none
module cct_cell
    import cct_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cct_cmd_t          cmd,
    input  wire logic [ADDR_W-1:0] req_addr,
    input  wire logic              prev_valid,
    input  wire logic              hit_in,
    input  wire logic [ADDR_W-1:0] next_addr,
    input  wire logic              next_valid,
    output logic [ADDR_W-1:0]      addr_out,
    output logic                   valid_out,
    output logic                   hit_out
);

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              valid_reg, valid_next;
    logic              match;

    assign match     = valid_reg && (addr_reg == req_addr);
    assign hit_out   = hit_in | match;
    assign addr_out  = addr_reg;
    assign valid_out = valid_reg;

    always_comb
    begin
        addr_next  = addr_reg;
        valid_next = valid_reg;
        if (cmd.do_clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.do_remove && hit_out)
        begin
            addr_next  = next_addr;
            valid_next = next_valid;
        end
        else if (cmd.do_append && !valid_reg && prev_valid)
        begin
            addr_next  = req_addr;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

endmodule
`default_nettype wire

// ----- rtl/compacting_client_table.sv -----
// Top level of the compacting client table: cell row, count, limit, response register.
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        opcode[1:0], client_address[31:0]
//  rsp      out  valid/ready        client_count[4:0], status[2:0]
//  cfg      in   cfg_wr_en          cfg_wr_data[4:0] = client_limit
//
// One request per cycle while req.ready is high; each request is resolved in the cycle it is accepted.
// The response is registered: it appears in the cycle after acceptance and is held in the output register.
// req.ready is high while the response register is empty or being taken.
// Reset empties the table and sets the limit to 16; no clearing pass.
`default_nettype none
module compacting_client_table
    import cct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data,
    cct_req_if.sink                 req,
    cct_rsp_if.source               rsp
);

    logic [LIMIT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [COUNT_OUT_W-1:0] rsp_count_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic [STATUS_W-1:0]    status_next;

    logic                   accept;
    logic                   any_match;
    logic                   full;
    logic [CMP_W-1:0]       cmp_count, cmp_limit, cmp_eff;
    cct_cmd_t               cmd;

    logic [ADDR_W-1:0]      cell_addr  [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] cell_valid;
    logic [MAX_CLIENTS-1:0] cell_hit;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign any_match = cell_hit[MAX_CLIENTS-1];
    assign cmp_count = CMP_W'(count_reg);
    assign cmp_limit = CMP_W'(limit_reg);
    assign cmp_eff   = (cmp_limit > CMP_W'(MAX_CLIENTS)) ? CMP_W'(MAX_CLIENTS) : cmp_limit;
    assign full      = cmp_count >= cmp_eff;

    always_comb
    begin
        cmd         = '0;
        count_next  = count_reg;
        status_next = ST_NOT_FOUND;
        case (req.opcode)
            OP_CONNECT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (any_match)
                begin
                    status_next = ST_LISTED;
                end
                else
                begin
                    cmd.do_append = accept;
                    count_next    = count_reg + CNT_W'(1);
                    status_next   = ST_ADDED;
                end
            end
            OP_DISCONNECT:
            begin
                if (any_match)
                begin
                    cmd.do_remove = accept;
                    count_next    = count_reg - CNT_W'(1);
                    status_next   = ST_REMOVED;
                end
            end
            OP_CLEAR:
            begin
                cmd.do_clear = accept;
                count_next   = '0;
                status_next  = ST_CLEARED;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    for (genvar i = 0; i < MAX_CLIENTS; i++)
    begin : g_cell
        logic              prev_valid;
        logic              hit_in;
        logic [ADDR_W-1:0] next_addr;
        logic              next_valid;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
            assign hit_in     = 1'b0;
        end
        else
        begin : g_mid
            assign prev_valid = cell_valid[i-1];
            assign hit_in     = cell_hit[i-1];
        end

        if (i == MAX_CLIENTS - 1)
        begin : g_last
            assign next_addr  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner
            assign next_addr  = cell_addr[i+1];
            assign next_valid = cell_valid[i+1];
        end

        cct_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .req_addr   (req.client_address),
            .prev_valid (prev_valid),
            .hit_in     (hit_in),
            .next_addr  (next_addr),
            .next_valid (next_valid),
            .addr_out   (cell_addr[i]),
            .valid_out  (cell_valid[i]),
            .hit_out    (cell_hit[i])
        );
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_count_reg  <= COUNT_OUT_W'(count_next);
            rsp_status_reg <= status_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.client_count = rsp_count_reg;
    assign rsp.status       = rsp_status_reg;

endmodule
`default_nettype wire

// ----- rtl/cct_checker.sv -----
// Port-level assertions for the client table, bound to the top level.
`default_nettype none
module cct_checker
    import cct_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_ready,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic [COUNT_OUT_W-1:0] client_count,
    input wire logic [STATUS_W-1:0]    status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(client_count) && $stable(status))
        else $error("response changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with empty response register");

    a_cleared_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_CLEARED |-> client_count == '0)
        else $error("clear reported a nonzero count");

    a_added_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_ADDED || status == ST_LISTED || status == ST_REMOVED
                      || status == ST_CLEARED || status == ST_FULL || status == ST_NOT_FOUND)
        |-> !(status == ST_ADDED && client_count == '0))
        else $error("add reported an empty table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> COUNT_OUT_W'(client_count) <= COUNT_OUT_W'(MAX_CLIENTS)
                      && status <= ST_CLEARED)
        else $error("response out of range");

endmodule

bind compacting_client_table cct_checker u_cct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .client_count (rsp.client_count),
    .status       (rsp.status)
);
`default_nettype wire
